// ===== hw/rtl/lu8d_pkg.sv =====
// Package for the lenient UTF-8 decoder: beat types, decode constants and
// the lead-byte and code-point helper functions. No dependencies.
`default_nettype none

package lu8d_pkg;

    localparam int MaxRes  = 4;
    localparam int ResCntW = $clog2(MaxRes + 1);
    localparam int HeldMax = 3;
    localparam int CpW     = 21;

    localparam logic [CpW-1:0] SubstChar = CpW'(63);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           substituted;
        logic           run_end;
        logic           text_end;
    } t_out;

    typedef struct packed {
        logic [ResCntW-1:0]     cnt;
        t_out [MaxRes-1:0]      res;
    } t_burst;

    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] l;
        if ((c & 8'h80) == 8'h00) begin
            l = 3'd1;
        end else if ((c & 8'hE0) == 8'hC0) begin
            l = 3'd2;
        end else if ((c & 8'hF0) == 8'hE0) begin
            l = 3'd3;
        end else if ((c & 8'hF8) == 8'hF0) begin
            l = 3'd4;
        end else begin
            l = 3'd0;
        end
        return l;
    endfunction

    function automatic logic [CpW-1:0] assemble(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] len
    );
        logic [CpW-1:0] cp;
        case (len)
            3'd1: begin
                cp = {13'd0, b0};
            end
            3'd2: begin
                cp = {10'd0, b0[4:0], b1[5:0]};
            end
            3'd3: begin
                cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            end
            default: begin
                cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            end
        endcase
        return cp;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lu8d_in_reg.sv =====
// Input register of the lenient UTF-8 decoder: holds one accepted byte beat
// until the decode stage takes it. Depends on lu8d_pkg.
`default_nettype none

module lu8d_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire lu8d_pkg::t_in i_data,
    input  wire logic          i_take,
    output logic               o_valid,
    output lu8d_pkg::t_in      o_data
);
    import lu8d_pkg::*;

    logic r_valid;
    t_in  r_data;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lu8d_decode.sv =====
// Decode stage of the lenient UTF-8 decoder: held sequence bytes and the
// single-pass decode of one byte beat into a burst of results. Depends on lu8d_pkg.
`default_nettype none

module lu8d_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire lu8d_pkg::t_in i_data,
    output lu8d_pkg::t_burst   o_burst
);
    import lu8d_pkg::*;

    logic [7:0] r_held [HeldMax];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       n_hold;

    always_comb begin
        logic [7:0]         bytes [7];
        logic [2:0]         total;
        logic [2:0]         pos;
        logic [2:0]         l;
        logic [2:0]         l0;
        logic [2:0]         alen;
        logic [ResCntW-1:0] n;
        t_burst             b;
        b      = '0;
        n      = '0;
        pos    = '0;
        l      = '0;
        n_hold = 1'b0;
        n_cnt  = 2'd0;
        total  = {1'b0, r_cnt} + 3'd1;
        for (int k = 0; k < 7; k++) begin
            if (k < HeldMax && 3'(k) < {1'b0, r_cnt}) begin
                bytes[k] = r_held[k];
            end else if (3'(k) == {1'b0, r_cnt}) begin
                bytes[k] = i_data.text_byte;
            end else begin
                bytes[k] = 8'd0;
            end
        end
        l0   = seq_len(bytes[0]);
        alen = (l0 == 3'd0) ? 3'd1 : l0;

        if (i_data.final_byte) begin
            for (int s = 0; s < MaxRes; s++) begin
                if (pos < total) begin
                    l = seq_len(bytes[pos]);
                    if (l != 3'd0 && ({1'b0, pos} + {1'b0, l}) <= {1'b0, total}) begin
                        b.res[n[1:0]].code_point = assemble(bytes[pos], bytes[pos + 3'd1],
                            bytes[pos + 3'd2], bytes[pos + 3'd3], l);
                        pos = pos + l;
                    end else begin
                        b.res[n[1:0]].code_point  = SubstChar;
                        b.res[n[1:0]].substituted = 1'b1;
                        pos = pos + 3'd1;
                    end
                    n = n + ResCntW'(1);
                end
            end
        end else if (r_cnt == 2'd0) begin
            if (l0 == 3'd1) begin
                b.res[0].code_point = {13'd0, i_data.text_byte};
                n = ResCntW'(1);
            end else if (l0 == 3'd0) begin
                b.res[0].code_point  = SubstChar;
                b.res[0].substituted = 1'b1;
                n = ResCntW'(1);
            end else begin
                n_hold = 1'b1;
                n_cnt  = 2'd1;
            end
        end else begin
            if (l0 == 3'd0 || total >= l0) begin
                b.res[0].code_point = assemble(bytes[0], bytes[1], bytes[2], bytes[3], alen);
                n = ResCntW'(1);
            end else begin
                n_hold = 1'b1;
                n_cnt  = r_cnt + 2'd1;
            end
        end

        if (n != '0) begin
            b.res[2'(n - ResCntW'(1))].run_end  = 1'b1;
            b.res[2'(n - ResCntW'(1))].text_end = i_data.final_byte;
        end
        b.cnt   = n;
        o_burst = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_take) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && n_hold) begin
            r_held[r_cnt] <= i_data.text_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lu8d_burst.sv =====
// Result register of the lenient UTF-8 decoder: holds the results of one
// byte beat and shifts them out one beat at a time. Depends on lu8d_pkg.
`default_nettype none

module lu8d_burst (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire lu8d_pkg::t_burst i_burst,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output lu8d_pkg::t_out        o_data
);
    import lu8d_pkg::*;

    logic [ResCntW-1:0] r_cnt;
    t_out [MaxRes-1:0]  r_res;
    logic               out_take;

    assign o_valid  = (r_cnt != '0);
    assign o_data   = r_res[0];
    assign out_take = o_valid && !i_stall;
    assign o_free   = (r_cnt == '0) || (r_cnt == ResCntW'(1) && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (out_take) begin
            r_cnt <= r_cnt - ResCntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_burst.res;
        end else if (out_take) begin
            r_res <= {t_out'('0), r_res[MaxRes-1:1]};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lenient_utf8_decoder_core.sv =====
// Top level of the lenient UTF-8 decoder: input register, decode stage and
// result register. Depends on lu8d_pkg, lu8d_in_reg, lu8d_decode, lu8d_burst.
//
// Use: the input channel (i_valid, o_stall, i_data) takes one text byte per
// beat, with final_byte set on the last byte of a text. The output channel
// (o_valid, i_stall, o_data) gives one code point per beat; run_end marks the
// last result of an input byte and text_end the last result of a text.
// A byte that only extends a pending multi-byte sequence gives no result.
// A byte passes the input register, decode and then the result register.
// Throughput without receiver stalls: one byte per cycle while each byte
// gives at most one result; a final byte that flushes held bytes gives up to
// three results, one per cycle, and the input waits for the last to be taken.
// Reset (synchronous, i_rst_n low) empties both registers and drops any held
// partial sequence. When the receiver stalls, the current result holds and
// o_stall rises once the input register is also full.
`default_nettype none

module lenient_utf8_decoder_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire lu8d_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output lu8d_pkg::t_out      o_data
);
    import lu8d_pkg::*;

    logic   in_valid;
    t_in    in_data;
    logic   take;
    logic   free;
    t_burst burst;

    assign take = in_valid && free;

    lu8d_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_take  (take),
        .o_valid (in_valid),
        .o_data  (in_data)
    );

    lu8d_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (in_data),
        .o_burst (burst)
    );

    lu8d_burst u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_burst (burst),
        .o_free  (free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire
